FILE: rtl/tss_pkg.sv
// Triangle span package: widths, screen constants and stage types.
// No dependencies; imported by every module of the span core.
`default_nettype none
package tss_pkg;
    localparam int unsigned SCREEN_WIDTH_DEF  = 320;
    localparam int unsigned SCREEN_HEIGHT_DEF = 224;
    localparam int unsigned DIV_W    = 17;   // divisor magnitude width (|dy| < 2^17)
    localparam int unsigned NUM_W    = 34;   // dividend magnitude width
    localparam int unsigned X_W      = 18;   // signed x after intersection
    localparam int unsigned IN_W     = 112;  // packed input tdata width
    localparam int unsigned OUT_W    = 56;   // packed result tdata width (52 used)

    // per-edge setup leaving the setup stages
    typedef struct packed {
        logic             covers;
        logic             flat;
        logic             neg;              // sign of quotient
        logic [NUM_W-1:0] num;              // |dx * (row - ay)|
        logic [DIV_W-1:0] den;              // |by - ay|
        logic [X_W-1:0]   ax;               // start x, also first flat end
        logic [X_W-1:0]   bx;               // second flat end
    } edge_setup_t;

    // per-edge outcome into the span reduction
    typedef struct packed {
        logic           covers;
        logic           flat;
        logic [X_W-1:0] xa;
        logic [X_W-1:0] xb;
    } edge_x_t;
endpackage
`default_nettype wire

FILE: rtl/tss_edge_setup.sv
// Edge setup: coverage test, differences and magnitude of dx*(row-ay).
// Depends on tss_pkg. One registered stage, product registered afterwards.
`default_nettype none
module tss_edge_setup
    import tss_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic signed [15:0] ax,
    input  wire logic signed [15:0] ay,
    input  wire logic signed [15:0] bx,
    input  wire logic signed [15:0] by,
    input  wire logic        [7:0]  row,
    output edge_setup_t             setup
);
    logic signed [16:0] dx, dy, dr;
    logic        [16:0] mdx, mdy, mdr;
    logic               cov, flt, neg;
    // stage A registers
    logic [16:0] mdx_reg, mdy_reg, mdr_reg;
    logic        cov_reg, flt_reg, neg_reg;
    logic [X_W-1:0] ax_reg, bx_reg;
    // stage B registers
    logic [X_W-1:0] ax_d_reg, bx_d_reg;
    logic [16:0] mdy_d_reg;
    logic        cov_d_reg, flt_d_reg, neg_d_reg;
    logic [NUM_W-1:0] prod_reg;

    always_comb begin
        dx  = 17'(bx) - 17'(ax);
        dy  = 17'(by) - 17'(ay);
        dr  = $signed({9'd0, row}) - 17'(ay);
        mdx = dx[16] ? 17'(-dx) : 17'(dx);
        mdy = dy[16] ? 17'(-dy) : 17'(dy);
        mdr = dr[16] ? 17'(-dr) : 17'(dr);
        cov = (($signed({9'd0, row}) >= 17'(ay)) && ($signed({9'd0, row}) <= 17'(by)))
           || (($signed({9'd0, row}) >= 17'(by)) && ($signed({9'd0, row}) <= 17'(ay)));
        flt = (ay == by);
        neg = dx[16] ^ dr[16] ^ dy[16];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mdx_reg <= mdx; mdy_reg <= mdy; mdr_reg <= mdr;
            cov_reg <= cov; flt_reg <= flt; neg_reg <= neg;
            ax_reg  <= X_W'(ax); bx_reg <= X_W'(bx);
            prod_reg <= NUM_W'(mdx_reg) * NUM_W'(mdr_reg);
            mdy_d_reg <= mdy_reg; cov_d_reg <= cov_reg; flt_d_reg <= flt_reg;
            neg_d_reg <= neg_reg; ax_d_reg <= ax_reg; bx_d_reg <= bx_reg;
        end
    end

    assign setup.covers = cov_d_reg;
    assign setup.flat   = flt_d_reg;
    assign setup.neg    = neg_d_reg;
    assign setup.num    = prod_reg;
    assign setup.den    = mdy_d_reg;
    assign setup.ax     = ax_d_reg;
    assign setup.bx     = bx_d_reg;
endmodule
`default_nettype wire

FILE: rtl/tss_divider.sv
// Pipelined restoring divider, one quotient bit per stage, truncating.
// Depends on tss_pkg. Adds x start to the signed quotient at the end (non-flat edges).
`default_nettype none
module tss_divider
    import tss_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        en,
    input  edge_setup_t      setup,
    output edge_x_t          result
);
    localparam int NS = int'(NUM_W);
    logic [DIV_W:0]   rem_in   [NS];
    logic [NUM_W-1:0] quo_in   [NS];
    edge_setup_t      side_in  [NS];
    logic [DIV_W:0]   rem_reg  [NS];
    logic [NUM_W-1:0] quo_reg  [NS];
    edge_setup_t      side_reg [NS];
    logic [DIV_W:0]   trial [NS];
    logic [DIV_W:0]   sub   [NS];
    edge_x_t          res_reg;
    logic [X_W-1:0]   q;

    // stage i works on the output of stage i-1; stage 0 on the setup
    always_comb begin
        rem_in[0]  = '0;
        quo_in[0]  = setup.num;
        side_in[0] = setup;
        for (int i = 1; i < NS; i++) begin
            rem_in[i]  = rem_reg[i-1];
            quo_in[i]  = quo_reg[i-1];
            side_in[i] = side_reg[i-1];
        end
        for (int i = 0; i < NS; i++) begin
            trial[i] = {rem_in[i][DIV_W-1:0], quo_in[i][NUM_W-1]};
            sub[i]   = trial[i] - {1'b0, side_in[i].den};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NS; i++) begin
                side_reg[i] <= side_in[i];
                if (!sub[i][DIV_W]) begin
                    rem_reg[i] <= sub[i];
                    quo_reg[i] <= {quo_in[i][NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg[i] <= trial[i];
                    quo_reg[i] <= {quo_in[i][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // quotient stays below 2^17 whenever the edge covers the row
    assign q = side_reg[NS-1].neg ? X_W'(-quo_reg[NS-1][X_W-1:0])
                                  : quo_reg[NS-1][X_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.covers <= side_reg[NS-1].covers;
            res_reg.flat   <= side_reg[NS-1].flat;
            res_reg.xa     <= side_reg[NS-1].flat ? side_reg[NS-1].ax
                                                  : side_reg[NS-1].ax + q;
            res_reg.xb     <= side_reg[NS-1].bx;
        end
    end
    assign result = res_reg;
endmodule
`default_nettype wire

FILE: rtl/tss_span_reduce.sv
// Span reduction: min/max of edge x values, clip, row address.
// Depends on tss_pkg. Two register stages.
`default_nettype none
module tss_span_reduce
    import tss_pkg::*;
#(
    parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire logic       aclk,
    input  wire logic       en,
    input  edge_x_t         e0,
    input  edge_x_t         e1,
    input  edge_x_t         e2,
    input  wire logic [7:0] row,
    output logic            span_valid,
    output logic [8:0]      span_start_x,
    output logic [8:0]      span_end_x,
    output logic [16:0]     start_address
);
    localparam logic signed [X_W+1:0] W_LAST = (X_W+2)'(SCREEN_WIDTH - 1);
    localparam logic [12:0] H = 13'(SCREEN_HEIGHT);
    logic signed [X_W-1:0] cand [6];
    logic                  use_c [6];
    logic signed [X_W-1:0] lo, hi;
    logic                  any;
    logic signed [X_W-1:0] lo_reg, hi_reg;
    logic                  any_reg, row_ok_reg;
    logic [7:0]            row_reg;
    logic signed [X_W+1:0] clo, chi;
    logic                  ok;
    logic [8:0]            sx_n, ex_n;
    logic [16:0]           addr_n;
    logic                  valid_reg;
    logic [8:0]            sx_reg, ex_reg;
    logic [16:0]           addr_reg;

    always_comb begin
        cand[0] = e0.xa; cand[1] = e0.xb; cand[2] = e1.xa;
        cand[3] = e1.xb; cand[4] = e2.xa; cand[5] = e2.xb;
        use_c[0] = e0.covers; use_c[1] = e0.covers && e0.flat;
        use_c[2] = e1.covers; use_c[3] = e1.covers && e1.flat;
        use_c[4] = e2.covers; use_c[5] = e2.covers && e2.flat;
        any = 1'b0; lo = '0; hi = '0;
        for (int i = 0; i < 6; i++) begin
            if (use_c[i]) begin
                if (!any || cand[i] < lo) lo = cand[i];
                if (!any || cand[i] > hi) hi = cand[i];
                any = 1'b1;
            end
        end
    end

    always_comb begin
        clo = (X_W+2)'(lo_reg);
        chi = (X_W+2)'(hi_reg);
        if (clo < 0) clo = '0;
        if (chi > W_LAST) chi = W_LAST;
        ok = any_reg && row_ok_reg && (clo <= chi);
        sx_n = ok ? clo[8:0] : '0;
        ex_n = ok ? chi[8:0] : '0;
        addr_n = ok ? 17'(32'(row_reg) * 32'(SCREEN_WIDTH) + 32'(clo[X_W-1:0])) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg <= lo; hi_reg <= hi; any_reg <= any;
            row_ok_reg <= (13'(row) < H);
            row_reg <= row;
            valid_reg <= ok; sx_reg <= sx_n; ex_reg <= ex_n;
            addr_reg <= addr_n;
        end
    end

    assign span_valid    = valid_reg;
    assign span_start_x  = sx_reg;
    assign span_end_x    = ex_reg;
    assign start_address = addr_reg;
endmodule
`default_nettype wire

FILE: rtl/triangle_scanline_span_core.sv
// Top level of the triangle scanline span core.
// Depends on tss_pkg, tss_edge_setup, tss_divider, tss_span_reduce.
//
// Channel   | direction | tdata fields (lowest bit first)
// s_axis    | in        | a_x, a_y, b_x, b_y, c_x, c_y, scan_row, fill_colour
// m_axis    | out       | span_valid, span_row, span_start_x, span_end_x,
//           |           | start_address, span_colour, zero pad
//
// One transfer a cycle sustained while m_tready does not stall; the pipe holds LAT stages:
// two setup stages (differences, then the 17x17 product), 34 divider stages of one
// quotient bit each, the divider output register, and two reduction stages.
// Reset clears only the valid bits; the data path needs none.
// The whole pipe advances together; it moves when the output slot is empty
// or being taken, so a stall holds every stage and nothing is lost or repeated.
// Holding m_tready low against a waiting result stalls the whole pipe and delays every result in flight.
`default_nettype none
module triangle_scanline_span_core
    import tss_pkg::*;
#(
    parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // a_x[15:0] a_y[31:16] b_x[47:32] b_y[63:48] c_x[79:64] c_y[95:80]
    // scan_row[103:96] fill_colour[111:104]
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // span_valid[0] span_row[8:1] span_start_x[17:9] span_end_x[26:18]
    // start_address[43:27] span_colour[51:44] zero[55:52]
    output logic [OUT_W-1:0]      m_tdata
);
    localparam int unsigned LAT = 2 + NUM_W + 1 + 2;   // stages entry to output

    logic               en;
    logic [LAT-1:0]     vld_reg;
    logic [7:0]         row_pipe_reg [LAT];
    logic [7:0]         col_pipe_reg [LAT];
    edge_setup_t        su [3];
    edge_x_t            ex [3];
    logic               sv;
    logic [8:0]         sx, exx;
    logic [16:0]        addr;
    logic signed [15:0] vx [3], vy [3];
    logic [7:0]         row;

    // the pipe advances when its last slot is empty or being taken
    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    assign row = s_tdata[103:96];
    for (genvar k = 0; k < 3; k++) begin : g_edge
        assign vx[k] = s_tdata[32*k +: 16];
        assign vy[k] = s_tdata[32*k+16 +: 16];
        tss_edge_setup u_setup (
            .aclk(aclk), .en(en),
            .ax(vx[k]), .ay(vy[k]), .bx(vx[(k+1)%3]), .by(vy[(k+1)%3]),
            .row(row), .setup(su[k])
        );
        tss_divider u_div (.aclk(aclk), .en(en), .setup(su[k]), .result(ex[k]));
    end

    tss_span_reduce #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_red (
        .aclk(aclk), .en(en), .e0(ex[0]), .e1(ex[1]), .e2(ex[2]),
        .row(row_pipe_reg[LAT-3]),
        .span_valid(sv), .span_start_x(sx), .span_end_x(exx), .start_address(addr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            row_pipe_reg[0] <= row;
            col_pipe_reg[0] <= s_tdata[111:104];
            for (int i = 1; i < LAT; i++) begin
                row_pipe_reg[i] <= row_pipe_reg[i-1];
                col_pipe_reg[i] <= col_pipe_reg[i-1];
            end
        end
    end

    assign m_tdata = {4'd0, col_pipe_reg[LAT-1], addr, exx, sx, row_pipe_reg[LAT-1], sv};
endmodule
`default_nettype wire
